@@ rtl/mqrb_pkg.sv @@
// Shared types and constants for the multi-queue ring buffer.
package mqrb_pkg;

    localparam int QID_W        = 4;
    localparam int PAYLOAD_W    = 64;
    localparam int SLOTS_CFG_W  = 7;
    localparam int QUEUES_CFG_W = 3;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_ADDR_W   = 1;
    localparam int S_TDATA_W    = 72;

    localparam logic [SLOTS_CFG_W-1:0]  SLOTS_RESET  = 7'd64;
    localparam logic [QUEUES_CFG_W-1:0] QUEUES_RESET = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SLOTS  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUEUES = 1'b1;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CHECK,
        BS_MOD,
        BS_DECIDE,
        BS_RDWAIT
    } back_state_t;

    // Classified operation handed from front to back
    typedef struct packed {
        cmd_t                 cmd;
        logic                 invalid;
        logic [QID_W-1:0]     qid;
        logic [PAYLOAD_W-1:0] payload;
    } op_t;

endpackage

@@ rtl/mqrb_front.sv @@
// Front end: configuration registers, input acceptance and queue-id check.
module mqrb_front import mqrb_pkg::*; #(
    parameter int NUM_QUEUES = 4,
    parameter int MAX_SLOTS  = 64,
    parameter int SLOT_BITS  = 64,
    parameter int CNT_W      = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  fifo_full,
    output logic                  push,
    output op_t                   push_op,
    output logic [CNT_W-1:0]      slots_eff
);

    localparam int CMP_W = (CNT_W > SLOTS_CFG_W) ? CNT_W : SLOTS_CFG_W;
    localparam int QCMP_W = QID_W + 1;

    logic [SLOTS_CFG_W-1:0]  slots_reg;
    logic [QUEUES_CFG_W-1:0] queues_reg;
    logic [QCMP_W-1:0]       queues_eff;
    logic [PAYLOAD_W-1:0]    payload_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg  <= SLOTS_RESET;
            queues_reg <= QUEUES_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SLOTS:  slots_reg  <= cfg_wdata[SLOTS_CFG_W-1:0];
                REG_QUEUES: queues_reg <= cfg_wdata[QUEUES_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp slot count to [2, MAX_SLOTS], queue count to NUM_QUEUES
    always_comb begin
        if (CMP_W'(slots_reg) < CMP_W'(2))
            slots_eff = CNT_W'(2);
        else if (CMP_W'(slots_reg) > CMP_W'(MAX_SLOTS))
            slots_eff = CNT_W'(MAX_SLOTS);
        else
            slots_eff = CNT_W'(slots_reg);

        if (QCMP_W'(queues_reg) > QCMP_W'(NUM_QUEUES))
            queues_eff = QCMP_W'(NUM_QUEUES);
        else
            queues_eff = QCMP_W'(queues_reg);
    end

    assign payload_mask = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - SLOT_BITS);

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_op.cmd     = cmd_t'(s_tuser);
        push_op.qid     = s_tdata[QID_W-1:0];
        push_op.invalid = QCMP_W'(s_tdata[QID_W-1:0]) >= queues_eff;
        push_op.payload = s_tdata[QID_W +: PAYLOAD_W] & payload_mask;
    end

endmodule

@@ rtl/mqrb_fifo.sv @@
// Two-entry operation queue between front and back.
module mqrb_fifo import mqrb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic full,
    output logic empty
);

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    assign head_op = entry_reg[rd_ptr_reg];
    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;

endmodule

@@ rtl/mqrb_back.sv @@
// Back end: index tables, slot memory, wrap unit and result register.
module mqrb_back import mqrb_pkg::*; #(
    parameter int NUM_QUEUES = 4,
    parameter int MAX_SLOTS  = 64,
    parameter int SLOT_BITS  = 64,
    parameter int CNT_W      = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fifo_empty,
    input  op_t                  head_op,
    output logic                 pop,
    input  logic [CNT_W-1:0]     slots_eff,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PAYLOAD_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int REM_W  = IDX_W + 1;
    localparam int DIV_W  = REM_W + IDX_W;
    localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DEPTH  = NUM_QUEUES * MAX_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);

    back_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic [IDX_W-1:0]  r_reg, r_next, w_reg, w_next, wrap_reg, wrap_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [PAYLOAD_W-1:0] out_data_reg, out_data_next;

    logic [IDX_W-1:0] rd_idx_reg [NUM_QUEUES];
    logic [IDX_W-1:0] wr_idx_reg [NUM_QUEUES];

    logic [SLOT_BITS-1:0] slot_mem [DEPTH];
    logic [SLOT_BITS-1:0] rd_data_reg;

    logic [QSEL_W-1:0] qsel;
    logic [IDX_W-1:0]  cur_r, cur_w;
    logic              out_free;
    logic              mem_we, mem_re, rd_we, wr_we;
    logic [ADDR_W-1:0] mem_addr;

    assign qsel     = op_reg.qid[QSEL_W-1:0];
    assign cur_r    = rd_idx_reg[qsel];
    assign cur_w    = wr_idx_reg[qsel];
    assign out_free = !out_valid_reg || m_tready;
    assign mem_addr = ADDR_W'(qsel) * ADDR_W'(MAX_SLOTS)
                    + ADDR_W'((op_reg.cmd == CMD_DEQ) ? r_reg : w_reg);

    always_comb begin
        logic [REM_W-1:0] v;
        logic [REM_W-1:0] rem_step;

        state_next      = state_reg;
        op_next         = op_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        wrap_next       = wrap_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_we           = 1'b0;
        wr_we           = 1'b0;
        v               = REM_W'((op_reg.cmd == CMD_DEQ) ? cur_r : cur_w) + REM_W'(1);
        rem_step        = rem_reg;

        case (state_reg)
            BS_IDLE: begin
                if (!fifo_empty) begin
                    pop        = 1'b1;
                    op_next    = head_op;
                    state_next = BS_CHECK;
                end
            end
            BS_CHECK: begin
                if (op_reg.invalid) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_INVALID;
                        out_data_next   = '0;
                        state_next      = BS_IDLE;
                    end
                end else begin
                    r_next = cur_r;
                    w_next = cur_w;
                    if (v < REM_W'(slots_eff)) begin
                        wrap_next  = v[IDX_W-1:0];
                        state_next = BS_DECIDE;
                    end else if (v == REM_W'(slots_eff)) begin
                        wrap_next  = '0;
                        state_next = BS_DECIDE;
                    end else begin
                        // index left at or above a shrunk slot count: full modulo
                        rem_next   = v;
                        div_next   = DIV_W'(slots_eff) << (IDX_W - 1);
                        step_next  = STEP_W'(IDX_W - 1);
                        state_next = BS_MOD;
                    end
                end
            end
            BS_MOD: begin
                if (DIV_W'(rem_reg) >= div_reg)
                    rem_step = rem_reg - div_reg[REM_W-1:0];
                rem_next  = rem_step;
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    wrap_next  = rem_step[IDX_W-1:0];
                    state_next = BS_DECIDE;
                end
            end
            BS_DECIDE: begin
                if (op_reg.cmd == CMD_ENQ) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        state_next     = BS_IDLE;
                        if (wrap_reg == r_reg) begin
                            out_status_next = ST_FULL;
                        end else begin
                            out_status_next = ST_OK;
                            mem_we          = 1'b1;
                            wr_we           = 1'b1;
                        end
                    end
                end else if (r_reg == w_reg) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_EMPTY;
                        out_data_next   = '0;
                        state_next      = BS_IDLE;
                    end
                end else begin
                    mem_re     = 1'b1;
                    rd_we      = 1'b1;
                    state_next = BS_RDWAIT;
                end
            end
            BS_RDWAIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = PAYLOAD_W'(rd_data_reg);
                    state_next      = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                rd_idx_reg[i] <= '0;
                wr_idx_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (rd_we)
                rd_idx_reg[qsel] <= wrap_reg;
            if (wr_we)
                wr_idx_reg[qsel] <= wrap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        r_reg          <= r_next;
        w_reg          <= w_next;
        wrap_reg       <= wrap_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    // Shared slot memory, one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we)
            slot_mem[mem_addr] <= op_reg.payload[SLOT_BITS-1:0];
        if (mem_re)
            rd_data_reg <= slot_mem[mem_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/multi_queue_ring_buffer.sv @@
// Top level of the multi-queue ring buffer: front, op queue and back.
//
//  Channel   Dir  Handshake            Content
//  s_        in   s_tvalid/s_tready    tuser: cmd; tdata: qid, payload_in
//  m_        out  m_tvalid/m_tready    tuser: status; tdata: payload_out
//  cfg_      in   cfg_wr_en            cfg_addr selects slots_in_use / queues_in_use
//
// An operation passes from queue head to result register through the pop, index
// check and full/empty decision states; an invalid queue id is answered from the
// check state, and a successful dequeue also waits on the registered slot memory
// read. When an index sits at or above a reduced slot count, the wrap runs through
// the restoring modulo loop in the back end.
// The two-entry op queue lets the front take transfers while the back works.
// Reset (aresetn low, synchronous) zeroes all queue indices and restores the
// registers to 64 slots and 4 queues; slot memory contents are not cleared.
// A stalled m_ side holds the result register and, once the op queue fills,
// deasserts s_tready.
module multi_queue_ring_buffer import mqrb_pkg::*; #(
    parameter int NUM_QUEUES = 4,
    parameter int MAX_SLOTS  = 64,
    parameter int SLOT_BITS  = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // operation input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [3:0] qid, [67:4] payload_in, [71:68] zero
    input  logic                  s_tuser,   // [0] cmd
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PAYLOAD_W-1:0]  m_tdata,   // [63:0] payload_out
    output logic [1:0]            m_tuser    // [1:0] status
);

    // wide enough to hold MAX_SLOTS itself
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic             fifo_push;
    logic             fifo_pop;
    logic             fifo_full;
    logic             fifo_empty;
    op_t              push_op;
    op_t              head_op;
    logic [CNT_W-1:0] slots_eff;

    // Front: config registers, input transfer, queue-id classification
    mqrb_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .MAX_SLOTS  (MAX_SLOTS),
        .SLOT_BITS  (SLOT_BITS),
        .CNT_W      (CNT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .push_op   (push_op),
        .slots_eff (slots_eff)
    );

    // Decoupling queue
    mqrb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .push_op (push_op),
        .pop     (fifo_pop),
        .head_op (head_op),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // Back: full/empty test, index update, slot access, result register
    mqrb_back #(
        .NUM_QUEUES (NUM_QUEUES),
        .MAX_SLOTS  (MAX_SLOTS),
        .SLOT_BITS  (SLOT_BITS),
        .CNT_W      (CNT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .head_op    (head_op),
        .pop        (fifo_pop),
        .slots_eff  (slots_eff),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
